>>> design/tacm_pkg.sv
`default_nettype none
package tacm_pkg;

  // coordinate, timer and datapath widths, divider step count and queue depth
  localparam int COORD_BITS = 16;
  localparam int TIMER_BITS = 16;
  localparam int SPAN_W     = 14;
  localparam int LIMIT_W    = 16;
  localparam int OUT_W      = 16;
  localparam int PROD_W     = COORD_BITS + SPAN_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [OUT_W-1:0]      OUT_MAX   = {OUT_W{1'b1}};

  // apb register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam logic [2:0] REG_MIN_X  = 3'd0;
  localparam logic [2:0] REG_MAX_X  = 3'd1;
  localparam logic [2:0] REG_MIN_Y  = 3'd2;
  localparam logic [2:0] REG_MAX_Y  = 3'd3;
  localparam logic [2:0] REG_SPAN_X = 3'd4;
  localparam logic [2:0] REG_SPAN_Y = 3'd5;
  localparam logic [2:0] REG_TAP    = 3'd6;
  localparam logic [2:0] REG_CLAMP  = 3'd7;

  // reset values
  localparam logic [15:0]       RST_MIN_X  = 16'd0;
  localparam logic [15:0]       RST_MAX_X  = 16'd3220;
  localparam logic [15:0]       RST_MIN_Y  = 16'd0;
  localparam logic [15:0]       RST_MAX_Y  = 16'd1952;
  localparam logic [SPAN_W-1:0] RST_SPAN_X = 14'd1920;
  localparam logic [SPAN_W-1:0] RST_SPAN_Y = 14'd1080;
  localparam logic [LIMIT_W-1:0] RST_TAP   = 16'd200;

  // request codes
  localparam logic [1:0] ACT_AXIS    = 2'd0;
  localparam logic [1:0] ACT_CONTACT = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [5:0] AXIS_X      = 6'd0;
  localparam logic [5:0] AXIS_Y      = 6'd1;
  localparam logic [15:0] CONTACT_UP   = 16'd0;
  localparam logic [15:0] CONTACT_DOWN = 16'd1;

  // result kinds
  localparam logic [1:0] KIND_CURSOR  = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [15:0]        min_x;
    logic [15:0]        max_x;
    logic [15:0]        min_y;
    logic [15:0]        max_y;
    logic [SPAN_W-1:0]  span_x;
    logic [SPAN_W-1:0]  span_y;
    logic [LIMIT_W-1:0] tap_limit;
    logic               clamp_en;
  } cfg_t;

  typedef struct packed {
    logic                  click;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

>>> design/tacm_if.sv
`default_nettype none
interface tacm_pad_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  axis_code;
  logic [15:0] value;

  modport source (output valid, action, axis_code, value, input ready);
  modport sink (input valid, action, axis_code, value, output ready);
endinterface

interface tacm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic        last;

  modport source (output valid, kind, cursor_x, cursor_y, last, input ready);
  modport sink (input valid, kind, cursor_x, cursor_y, last, output ready);
endinterface
`default_nettype wire

>>> design/tacm_front.sv
`default_nettype none
module tacm_front (
  input  wire logic            clk,
  input  wire logic            rst,
  tacm_pad_if.sink             pad,
  input  wire tacm_pkg::cfg_t  cfg,
  input  wire tacm_pkg::q_stat_t q_stat,
  output logic                 push,
  output tacm_pkg::cmd_t       push_cmd
);
  import tacm_pkg::*;

  logic [COORD_BITS-1:0] held_x, held_y, held_x_next, held_y_next;
  logic                  x_fresh, y_fresh, x_fresh_next, y_fresh_next;
  logic                  tap_armed, tap_armed_next;
  logic [TIMER_BITS-1:0] tap_elapsed, tap_elapsed_next;
  logic                  accept;

  assign pad.ready = !q_stat.full;
  assign accept    = pad.valid && pad.ready;

  always_comb begin
    held_x_next      = held_x;
    held_y_next      = held_y;
    x_fresh_next     = x_fresh;
    y_fresh_next     = y_fresh;
    tap_armed_next   = tap_armed;
    tap_elapsed_next = tap_elapsed;
    push             = 1'b0;
    push_cmd         = '0;
    if (accept) begin
      case (pad.action)
        ACT_AXIS: begin
          if (pad.axis_code == AXIS_X) begin
            held_x_next  = pad.value;
            x_fresh_next = 1'b1;
          end else if (pad.axis_code == AXIS_Y) begin
            held_y_next  = pad.value;
            y_fresh_next = 1'b1;
          end
          if (cfg.clamp_en) begin
            if (held_x_next < cfg.min_x) held_x_next = cfg.min_x;
            if (held_x_next > cfg.max_x) held_x_next = cfg.max_x;
            if (held_y_next < cfg.min_y) held_y_next = cfg.min_y;
            if (held_y_next > cfg.max_y) held_y_next = cfg.max_y;
          end
          if (x_fresh_next && y_fresh_next) begin
            push           = 1'b1;
            push_cmd.click = 1'b0;
            push_cmd.x     = held_x_next;
            push_cmd.y     = held_y_next;
            x_fresh_next   = 1'b0;
            y_fresh_next   = 1'b0;
          end
        end
        ACT_CONTACT: begin
          if (pad.value == CONTACT_DOWN) begin
            tap_armed_next   = 1'b1;
            tap_elapsed_next = '0;
          end else if (pad.value == CONTACT_UP && tap_armed) begin
            tap_armed_next = 1'b0;
            if (tap_elapsed < cfg.tap_limit) begin
              push           = 1'b1;
              push_cmd.click = 1'b1;
            end
          end
        end
        ACT_TICK: begin
          if (tap_armed && tap_elapsed != TIMER_MAX) begin
            tap_elapsed_next = tap_elapsed + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x      <= '0;
      held_y      <= '0;
      x_fresh     <= 1'b0;
      y_fresh     <= 1'b0;
      tap_armed   <= 1'b0;
      tap_elapsed <= '0;
    end else begin
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      x_fresh     <= x_fresh_next;
      y_fresh     <= y_fresh_next;
      tap_armed   <= tap_armed_next;
      tap_elapsed <= tap_elapsed_next;
    end
  end

endmodule
`default_nettype wire

>>> design/tacm_queue.sv
`default_nettype none
module tacm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tacm_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output tacm_pkg::cmd_t      head,
  output tacm_pkg::q_stat_t   stat
);
  import tacm_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/tacm_back.sv
`default_nettype none
module tacm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tacm_pkg::cfg_t    cfg,
  input  wire tacm_pkg::q_stat_t q_stat,
  input  wire tacm_pkg::cmd_t    q_head,
  output logic                   pop,
  tacm_res_if.source             res
);
  import tacm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_CUR, S_PRESS, S_REL
  } state_t;

  state_t                state;
  logic [COORD_BITS-1:0] cmd_x, cmd_y;
  logic                  axis_y;
  logic [PROD_W-1:0]     prod, quo;
  logic [COORD_BITS-1:0] divisor, rem;
  logic                  empty_win;
  logic [STEP_W-1:0]     step;
  logic [OUT_W-1:0]      sx;

  logic                  out_valid, out_last;
  logic [1:0]            out_kind;
  logic [OUT_W-1:0]      out_x, out_y;

  // axis operand select
  logic [COORD_BITS-1:0] a_coord, a_lo, a_hi, a_diff;
  logic [SPAN_W-1:0]     a_span;
  logic [COORD_BITS:0]   rem_shift, rem_sub;
  logic                  ge;
  logic [PROD_W-1:0]     quo_fin;
  logic [OUT_W-1:0]      q_sat;
  logic                  out_free;
  logic                  out_load;

  assign out_free = !out_valid || res.ready;
  assign out_load = out_free && (state == S_CUR || state == S_PRESS || state == S_REL);
  assign pop      = (state == S_IDLE) && !q_stat.empty;

  always_comb begin
    a_coord = axis_y ? cmd_y : cmd_x;
    a_lo    = axis_y ? cfg.min_y : cfg.min_x;
    a_hi    = axis_y ? cfg.max_y : cfg.max_x;
    a_span  = axis_y ? cfg.span_y : cfg.span_x;
    a_diff  = (a_coord > a_lo) ? a_coord - a_lo : '0;
  end

  // one restoring divide step, with the quotient saturated to the output width
  always_comb begin
    rem_shift = {rem, prod[PROD_W-1]};
    ge        = rem_shift >= {1'b0, divisor};
    rem_sub   = ge ? rem_shift - {1'b0, divisor} : rem_shift;
    quo_fin   = {quo[PROD_W-2:0], ge};
    if (empty_win) begin
      q_sat = '0;
    end else if (|quo_fin[PROD_W-1:OUT_W]) begin
      q_sat = OUT_MAX;
    end else begin
      q_sat = quo_fin[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      axis_y    <= 1'b0;
      step      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cmd_x  <= q_head.x;
            cmd_y  <= q_head.y;
            axis_y <= 1'b0;
            state  <= q_head.click ? S_PRESS : S_MUL;
          end
        end
        S_MUL: begin
          prod      <= PROD_W'(a_diff) * PROD_W'(a_span);
          divisor   <= a_hi - a_lo;
          empty_win <= a_hi <= a_lo;
          rem       <= '0;
          quo       <= '0;
          step      <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_sub[COORD_BITS-1:0];
          prod <= {prod[PROD_W-2:0], 1'b0};
          // the saturated y quotient is parked in quo until the cursor is sent
          quo  <= (step == STEP_W'(DIV_STEPS-1) && axis_y) ? PROD_W'(q_sat) : quo_fin;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS-1)) begin
            if (axis_y) begin
              state <= S_CUR;
            end else begin
              sx     <= q_sat;
              axis_y <= 1'b1;
              state  <= S_MUL;
            end
          end
        end
        S_CUR: begin
          if (out_free) begin
            out_kind  <= KIND_CURSOR;
            out_x     <= sx;
            out_y     <= quo[OUT_W-1:0];
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_PRESS: begin
          if (out_free) begin
            out_kind  <= KIND_PRESS;
            out_x     <= '0;
            out_y     <= '0;
            out_last  <= 1'b0;
            state     <= S_REL;
          end
        end
        S_REL: begin
          if (out_free) begin
            out_kind  <= KIND_RELEASE;
            out_x     <= '0;
            out_y     <= '0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = out_valid;
  assign res.kind     = out_kind;
  assign res.cursor_x = out_x;
  assign res.cursor_y = out_y;
  assign res.last     = out_last;

endmodule
`default_nettype wire

>>> design/touchpad_absolute_cursor_mapper.sv
// channel   dir  handshake     payload
// pad       in   valid/ready   action[1:0] axis_code[5:0] value[15:0]
// res       out  valid/ready   kind[1:0] cursor_x[15:0] cursor_y[15:0] last
// apb       in   psel/penable  paddr[4:0] pwdata[31:0] -> prdata[31:0]
//
// the front takes one pad request per cycle while the 4-entry command queue has room
// a cursor result is computed after its completing axis report by a multiply state
//   then 30 restoring divide steps per axis on a shared divider
// a tap gives press then release on consecutive free output cycles
// rst is synchronous; it clears the tracking state, the queue, the output
//   register and loads the register defaults; no clearing pass
// a stalled res holds its result while the front keeps taking requests as long as the queue has room
`default_nettype none
module touchpad_absolute_cursor_mapper (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tacm_pad_if.sink                           pad,
  tacm_res_if.source                         res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tacm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tacm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tacm_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import tacm_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  cmd_t    push_cmd, q_head;
  logic    push, pop;
  logic    cfg_wr;

  // register file, written on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x     <= RST_MIN_X;
      cfg.max_x     <= RST_MAX_X;
      cfg.min_y     <= RST_MIN_Y;
      cfg.max_y     <= RST_MAX_Y;
      cfg.span_x    <= RST_SPAN_X;
      cfg.span_y    <= RST_SPAN_Y;
      cfg.tap_limit <= RST_TAP;
      cfg.clamp_en  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_X:  cfg.min_x     <= pwdata[15:0];
        REG_MAX_X:  cfg.max_x     <= pwdata[15:0];
        REG_MIN_Y:  cfg.min_y     <= pwdata[15:0];
        REG_MAX_Y:  cfg.max_y     <= pwdata[15:0];
        REG_SPAN_X: cfg.span_x    <= pwdata[SPAN_W-1:0];
        REG_SPAN_Y: cfg.span_y    <= pwdata[SPAN_W-1:0];
        REG_TAP:    cfg.tap_limit <= pwdata[LIMIT_W-1:0];
        REG_CLAMP:  cfg.clamp_en  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    case (paddr[4:2])
      REG_MIN_X:  prdata = PDATA_W'(cfg.min_x);
      REG_MAX_X:  prdata = PDATA_W'(cfg.max_x);
      REG_MIN_Y:  prdata = PDATA_W'(cfg.min_y);
      REG_MAX_Y:  prdata = PDATA_W'(cfg.max_y);
      REG_SPAN_X: prdata = PDATA_W'(cfg.span_x);
      REG_SPAN_Y: prdata = PDATA_W'(cfg.span_y);
      REG_TAP:    prdata = PDATA_W'(cfg.tap_limit);
      REG_CLAMP:  prdata = PDATA_W'(cfg.clamp_en);
      default:    prdata = '0;
    endcase
  end

  // front: tracks axes and tap timer, emits commands
  tacm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pad      (pad),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // short command queue decoupling front from the divider
  tacm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // back: scaling and result sequencing
  tacm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_head (q_head),
    .pop    (pop),
    .res    (res)
  );

  // a taken press is followed at once by its release
  a_press_then_release: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.kind == KIND_PRESS)
      |=> (res.valid && res.kind == KIND_RELEASE))
    else $error("press not followed by release");

  // only the press is a non-final result
  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.last == (res.kind != KIND_PRESS)))
    else $error("last flag does not match result kind");

  // button results carry no position
  a_button_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind != KIND_CURSOR) |-> (res.cursor_x == '0 && res.cursor_y == '0))
    else $error("button result carries a position");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
